// File: hdl/iefg_pkg.sv
// Shared types, constants and checksum helpers for the ICMP echo frame generator.
// No dependencies; imported by the builder and the top level.
`default_nettype none

package iefg_pkg;

	localparam int HDR_BYTES = 42;

	localparam logic [7:0]  IP_VER_IHL    = 8'h45;
	localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
	localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  BCAST_BYTE    = 8'hFF;

	localparam logic [47:0] SOURCE_MAC_RST = 48'h0;
	localparam logic [31:0] SOURCE_IP_RST  = 32'h0A00_020F;
	localparam logic [7:0]  TTL_RST        = 8'd64;
	localparam logic [15:0] IDENT_RST      = 16'h1234;
	localparam logic [15:0] SEQ_RST        = 16'h0001;

	typedef enum logic [2:0] {
		REG_SOURCE_MAC = 3'd0,
		REG_SOURCE_IP  = 3'd1,
		REG_TTL        = 3'd2,
		REG_IDENT      = 3'd3,
		REG_SEQ        = 3'd4
	} reg_idx_t;

	typedef logic [20:0] csum_acc_t;

	// Unfolded sum of 16-bit words over the incrementing payload, odd byte padded with zero
	function automatic csum_acc_t payload_sum(int n);
		int acc;
		acc = 0;
		for (int i = 0; i + 1 < n; i += 2) begin
			acc += (i << 8) | (i + 1);
		end
		if ((n & 1) != 0) begin
			acc += (n - 1) << 8;
		end
		return csum_acc_t'(acc);
	endfunction

	// end-around carry fold, then complement
	function automatic logic [15:0] csum_fold(csum_acc_t s);
		logic [16:0] a;
		logic [16:0] b;
		a = 17'(s[15:0]) + 17'(s[20:16]);
		b = 17'(a[15:0]) + 17'(a[16]);
		return ~b[15:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/iefg_cell.sv
// One word cell of the frame shift chain: parallel load or take neighbor's word.
// Depends on nothing but the clock.
`default_nettype none

module iefg_cell (
	input  wire logic        clk,
	input  wire logic        load,
	input  wire logic        shift,
	input  wire logic [15:0] load_word,
	input  wire logic [15:0] next_word,
	output logic      [15:0] word
);
	logic [15:0] word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end else if (shift) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

// File: hdl/iefg_builder.sv
// Assembles the Ethernet/IPv4/ICMP echo frame words and folds both checksums.
// Depends on iefg_pkg.
`default_nettype none

module iefg_builder #(
	parameter int PAYLOAD_BYTES = 32
) (
	input  wire logic [31:0]               dst_ip,
	input  wire logic [47:0]               src_mac,
	input  wire logic [31:0]               src_ip,
	input  wire logic [7:0]                ttl,
	input  wire logic [15:0]               ident,
	input  wire logic [15:0]               seq,
	input  wire iefg_pkg::csum_acc_t       ip_sum,
	input  wire iefg_pkg::csum_acc_t       icmp_sum,
	output logic [(iefg_pkg::HDR_BYTES + PAYLOAD_BYTES + 1) / 2 - 1:0][15:0] words
);
	import iefg_pkg::*;

	localparam int FRAME_BYTES = HDR_BYTES + PAYLOAD_BYTES;
	localparam int NW          = (FRAME_BYTES + 1) / 2;
	localparam logic [15:0] TOT_LEN = 16'(FRAME_BYTES - 14);

	logic [7:0]  b [0:2*NW-1];
	logic [15:0] ip_csum;
	logic [15:0] icmp_csum;

	assign ip_csum   = csum_fold(ip_sum);
	assign icmp_csum = csum_fold(icmp_sum);

	always_comb begin
		for (int i = 0; i < 2 * NW; i++) begin
			b[i] = 8'h00;
		end
		for (int i = 0; i < 6; i++) begin
			b[i]     = BCAST_BYTE;
			b[6 + i] = src_mac[47 - 8*i -: 8];
		end
		b[12] = ETH_TYPE_IPV4[15:8];
		b[13] = ETH_TYPE_IPV4[7:0];
		b[14] = IP_VER_IHL;
		b[16] = TOT_LEN[15:8];
		b[17] = TOT_LEN[7:0];
		b[22] = ttl;
		b[23] = IP_PROTO_ICMP;
		b[24] = ip_csum[15:8];
		b[25] = ip_csum[7:0];
		b[26] = src_ip[31:24];
		b[27] = src_ip[23:16];
		b[28] = src_ip[15:8];
		b[29] = src_ip[7:0];
		b[30] = dst_ip[31:24];
		b[31] = dst_ip[23:16];
		b[32] = dst_ip[15:8];
		b[33] = dst_ip[7:0];
		b[34] = ICMP_ECHO_REQ;
		b[36] = icmp_csum[15:8];
		b[37] = icmp_csum[7:0];
		b[38] = ident[15:8];
		b[39] = ident[7:0];
		b[40] = seq[15:8];
		b[41] = seq[7:0];
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			b[HDR_BYTES + i] = 8'(i);
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_word
		assign words[k] = {b[2*k], b[2*k + 1]};
	end

endmodule

`default_nettype wire

// File: hdl/icmp_echo_frame_generator_top.sv
// Top level of the ICMP echo frame generator: APB registers, request buffer,
// word cell chain. Depends on iefg_pkg, iefg_builder and iefg_cell.
//
//  channel | dir | handshake         | contents
//  s_*     | in  | s_tvalid/s_tready | request: destination IPv4 address
//  m_*     | out | m_tvalid/m_tready | one 16-bit frame word, tlast on final word
//  apb     | in  | psel/penable      | station MAC, source IP, TTL, id, sequence
//
// A frame is (42 + PAYLOAD_BYTES + 1) / 2 words (37 by default), one per cycle while
// m_tready is high, as set by the single output port of the cell chain.
// The next request loads into the chain at the edge its last word is taken,
// so frames run back to back; one further request waits in a buffer.
// A stalled m_tready freezes the chain. Reset clears control and loads the registers' reset values.
`default_nettype none

module icmp_echo_frame_generator_top #(
	parameter int PAYLOAD_BYTES = 32,
	parameter int TX_SLOTS      = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: [31:0] dest_ip
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,
	// m_tdata: [15:0] frame_word, [21:16] word_index, [28:22] frame_length, [31:29] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,
	output logic             m_tlast,
	// m_tuser: [1:0] tx_slot
	output logic      [1:0]  m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);
	import iefg_pkg::*;

	localparam int FRAME_BYTES = HDR_BYTES + PAYLOAD_BYTES;
	localparam int NW          = (FRAME_BYTES + 1) / 2;
	localparam int SLOT_W      = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
	localparam logic [5:0] LAST_IDX = 6'(NW - 1);
	localparam logic [6:0] FLEN     = 7'(FRAME_BYTES);
	localparam logic [15:0] TOT_LEN = 16'(FRAME_BYTES - 14);
	localparam csum_acc_t PAY_SUM   = payload_sum(PAYLOAD_BYTES);

	logic [47:0] src_mac_q;
	logic [31:0] src_ip_q;
	logic [7:0]  ttl_q;
	logic [15:0] ident_q;
	logic [15:0] seq_q;

	logic        pend_q;
	logic [31:0] dst_s1;
	csum_acc_t   ip_sum_s1;
	csum_acc_t   icmp_sum_s1;

	logic              busy_q;
	logic [5:0]        idx_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [2:0]        slot_ext;

	logic      cfg_wr;
	reg_idx_t  cfg_idx;
	logic      s_fire;
	logic      out_fire;
	logic      at_last;
	logic      load;
	csum_acc_t ip_sum;
	csum_acc_t icmp_sum;

	logic [NW-1:0][15:0] frame_words;
	logic [NW-1:0][15:0] chain;

	// configuration
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_mac_q <= SOURCE_MAC_RST;
			src_ip_q  <= SOURCE_IP_RST;
			ttl_q     <= TTL_RST;
			ident_q   <= IDENT_RST;
			seq_q     <= SEQ_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SOURCE_MAC: src_mac_q <= pwdata[47:0];
				REG_SOURCE_IP:  src_ip_q  <= pwdata[31:0];
				REG_TTL:        ttl_q     <= pwdata[7:0];
				REG_IDENT:      ident_q   <= pwdata[15:0];
				REG_SEQ:        seq_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SOURCE_MAC: prdata = 64'(src_mac_q);
			REG_SOURCE_IP:  prdata = 64'(src_ip_q);
			REG_TTL:        prdata = 64'(ttl_q);
			REG_IDENT:      prdata = 64'(ident_q);
			REG_SEQ:        prdata = 64'(seq_q);
			default:        prdata = 64'h0;
		endcase
	end

	// request buffer with raw checksum sums
	assign out_fire = m_tvalid & m_tready;
	assign at_last  = (idx_q == LAST_IDX);
	assign load     = pend_q & (~busy_q | (out_fire & at_last));
	assign s_tready = ~pend_q | load;
	assign s_fire   = s_tvalid & s_tready;

	assign ip_sum = csum_acc_t'({IP_VER_IHL, 8'h00}) + csum_acc_t'(TOT_LEN)
		+ csum_acc_t'({ttl_q, IP_PROTO_ICMP})
		+ csum_acc_t'(src_ip_q[31:16]) + csum_acc_t'(src_ip_q[15:0])
		+ csum_acc_t'(s_tdata[31:16]) + csum_acc_t'(s_tdata[15:0]);
	assign icmp_sum = csum_acc_t'({ICMP_ECHO_REQ, 8'h00}) + csum_acc_t'(ident_q)
		+ csum_acc_t'(seq_q) + PAY_SUM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (s_fire) begin
			pend_q <= 1'b1;
		end else if (load) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			dst_s1      <= s_tdata;
			ip_sum_s1   <= ip_sum;
			icmp_sum_s1 <= icmp_sum;
		end
	end

	iefg_builder #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_builder (
		.dst_ip   (dst_s1),
		.src_mac  (src_mac_q),
		.src_ip   (src_ip_q),
		.ttl      (ttl_q),
		.ident    (ident_q),
		.seq      (seq_q),
		.ip_sum   (ip_sum_s1),
		.icmp_sum (icmp_sum_s1),
		.words    (frame_words)
	);

	// word chain, head at cell 0
	for (genvar k = 0; k < NW; k++) begin : g_cell
		logic [15:0] nxt;
		if (k == NW - 1) begin : g_tail
			assign nxt = 16'h0;
		end else begin : g_mid
			assign nxt = chain[k + 1];
		end
		iefg_cell u_cell (
			.clk       (clk),
			.load      (load),
			.shift     (out_fire),
			.load_word (frame_words[k]),
			.next_word (nxt),
			.word      (chain[k])
		);
	end

	// frame sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			slot_q     <= '0;
			cur_slot_q <= '0;
		end else begin
			if (load) begin
				busy_q     <= 1'b1;
				idx_q      <= '0;
				cur_slot_q <= slot_q;
				slot_q     <= (slot_q == SLOT_W'(TX_SLOTS - 1)) ? '0 : slot_q + 1'b1;
			end else if (out_fire) begin
				idx_q <= idx_q + 6'd1;
				if (at_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign slot_ext = 3'(cur_slot_q);
	assign m_tvalid = busy_q;
	assign m_tdata  = {3'b000, FLEN, idx_q, chain[0]};
	assign m_tlast  = at_last;
	assign m_tuser  = slot_ext[1:0];

endmodule

`default_nettype wire

// File: hdl/iefg_checker.sv
// Port-level checks on the frame output stream of the ICMP echo frame generator.
// Bound to icmp_echo_frame_generator_top; no package dependency.
`default_nettype none

module iefg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic [1:0]  m_tuser
);

	// words of one frame follow without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside frame");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tdata[21:16] == $past(m_tdata[21:16]) + 6'd1)
		else $error("word index not consecutive");

	a_slot_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tuser == $past(m_tuser))
		else $error("slot changed inside frame");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |->
			{1'b0, m_tdata[21:16]} + 7'd1 == (m_tdata[28:22] + 7'd1) >> 1)
		else $error("last word at wrong index");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled word changed");

endmodule

bind icmp_echo_frame_generator_top iefg_checker u_iefg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
